// File: design/tlrq_pkg.sv
// shared types and codes for the two-level ready queue dispatcher
`default_nettype none

package tlrq_pkg;

   // fixed width of the id field on both channels
   localparam int ID_FIELD_BITS = 16;

   // scheduling policy codes; the unused code behaves as fifo
   localparam logic [1:0] POLICY_FIFO     = 2'd0;
   localparam logic [1:0] POLICY_RR       = 2'd1;
   localparam logic [1:0] POLICY_FEEDBACK = 2'd2;

   // operation codes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_PUSHED = 2'd0;
   localparam logic [1:0] STATUS_POPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   typedef struct packed {
      logic                     mode;
      logic [ID_FIELD_BITS-1:0] process_id;
      logic                     arrived_new_or_blocked;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [ID_FIELD_BITS-1:0] served_id;
      logic                     preemptible;
   } rsp_type;

   // per-queue command from the dispatch control
   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

endpackage

`default_nettype wire

// File: design/tlrq_queue.sv
// one circular id queue: synchronous store, head pointer and fill count
`default_nettype none

module tlrq_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_BITS   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tlrq_pkg::queue_cmd_type            cmd,
   input  wire logic [DATA_BITS-1:0]               push_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]        count,
   output logic [DATA_BITS-1:0]                    rd_data
);

   localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS  = CNT_BITS + 1;

   logic [DATA_BITS-1:0] store_mem [QUEUE_DEPTH];
   logic [ADDR_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [SUM_BITS-1:0]  tail_sum;
   logic [SUM_BITS-1:0]  tail_wrap;
   logic [ADDR_BITS-1:0] tail;

   // tail position is head plus count, wrapped once
   always_comb begin
      tail_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff);
      if (tail_sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         tail_wrap = tail_sum - SUM_BITS'(QUEUE_DEPTH);
      end else begin
         tail_wrap = tail_sum;
      end
      tail = tail_wrap[ADDR_BITS-1:0];
   end

   // pointer and count update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         if (head_ff == ADDR_BITS'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + ADDR_BITS'(1);
         end
      end
      if (cmd.push && !cmd.pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.pop && !cmd.push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // store write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[tail] <= push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= store_mem[head_ff];
      end
   end

   assign count   = count_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/two_level_ready_queue_dispatch_top.sv
// top level of the two-level ready queue dispatcher
//
// req channel: one transaction is a push of a process id or a pop of the next
// ready process. rsp channel: exactly one result per request, in order, with
// status, the id pushed or popped, and whether the round robin queue was used.
// csr channel: writes the 2-bit policy register; csr_ready is always high and
// writes are expected only while no request is in flight.
// Result path: the store read is registered at the accepting edge together
// with the work stage, and the output register loads from the work stage
// when it is free; rsp_valid rises once the output register holds the result.
// Throughput: one request per cycle while rsp is not stalled; the queue
// pointers and counts update at acceptance, so each request sees the state
// left by the one before it. The result passes through the store read
// register and then the output register.
// Reset empties both queues and sets the policy to fifo; no clearing pass is
// needed since entries are only read after being written.
// While rsp_stall is high the output register holds its result, one more
// request may be accepted and parked in the work stage, after which req_stall
// rises until the output drains.
`default_nettype none

module two_level_ready_queue_dispatch_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tlrq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tlrq_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_data
);

   localparam int FIELD_BITS = tlrq_pkg::ID_FIELD_BITS;
   localparam int STORE_BITS = (ID_BITS < FIELD_BITS) ? ID_BITS : FIELD_BITS;
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   logic [1:0]            policy_ff;
   logic                  req_accept;
   logic                  out_free;
   logic                  s1_move;
   logic                  is_rr;
   logic                  is_fb;
   logic                  push_robin;
   logic                  pop_robin;
   logic                  use_robin;
   logic [CNT_BITS-1:0]   robin_count;
   logic [CNT_BITS-1:0]   plain_count;
   logic [CNT_BITS-1:0]   sel_count;
   logic                  op_ok;
   logic [STORE_BITS-1:0] id_kept;
   logic [STORE_BITS-1:0] robin_rd;
   logic [STORE_BITS-1:0] plain_rd;
   tlrq_pkg::queue_cmd_type robin_cmd;
   tlrq_pkg::queue_cmd_type plain_cmd;

   // work stage: the accepted transaction waiting for its store read
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_pop_ff;
   logic                  s1_robin_ff;
   logic                  s1_ok_ff;
   logic [STORE_BITS-1:0] s1_id_ff;
   tlrq_pkg::rsp_type     s1_result;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   tlrq_pkg::rsp_type     rsp_data_ff;

   // policy register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= tlrq_pkg::POLICY_FIFO;
      end else if (csr_valid && csr_ready) begin
         policy_ff <= csr_data;
      end
   end

   // handshake control
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_move     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !s1_move;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // queue selection from policy and current fill
   always_comb begin
      is_rr      = (policy_ff == tlrq_pkg::POLICY_RR);
      is_fb      = (policy_ff == tlrq_pkg::POLICY_FEEDBACK);
      push_robin = is_rr || (is_fb && req_data.arrived_new_or_blocked);
      pop_robin  = is_rr || (is_fb && (robin_count != '0));
      use_robin  = (req_data.mode == tlrq_pkg::MODE_POP) ? pop_robin : push_robin;
      sel_count  = use_robin ? robin_count : plain_count;
      if (req_data.mode == tlrq_pkg::MODE_POP) begin
         op_ok = (sel_count != '0);
      end else begin
         op_ok = (sel_count != CNT_BITS'(QUEUE_DEPTH));
      end
      id_kept = req_data.process_id[STORE_BITS-1:0];
   end

   // queue commands
   always_comb begin
      robin_cmd.push = req_accept && op_ok && use_robin &&
                       (req_data.mode == tlrq_pkg::MODE_PUSH);
      robin_cmd.pop  = req_accept && op_ok && use_robin &&
                       (req_data.mode == tlrq_pkg::MODE_POP);
      plain_cmd.push = req_accept && op_ok && !use_robin &&
                       (req_data.mode == tlrq_pkg::MODE_PUSH);
      plain_cmd.pop  = req_accept && op_ok && !use_robin &&
                       (req_data.mode == tlrq_pkg::MODE_POP);
   end

   tlrq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_BITS   (STORE_BITS)
   ) u_robin_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (robin_cmd),
      .push_data (id_kept),
      .count     (robin_count),
      .rd_data   (robin_rd)
   );

   tlrq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_BITS   (STORE_BITS)
   ) u_plain_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (plain_cmd),
      .push_data (id_kept),
      .count     (plain_count),
      .rd_data   (plain_rd)
   );

   // work stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pop_ff   <= (req_data.mode == tlrq_pkg::MODE_POP);
         s1_robin_ff <= use_robin;
         s1_ok_ff    <= op_ok;
         s1_id_ff    <= id_kept;
      end
   end

   // result formation from the store read
   always_comb begin
      if (s1_pop_ff) begin
         if (s1_ok_ff) begin
            s1_result.status      = tlrq_pkg::STATUS_POPPED;
            s1_result.served_id   = FIELD_BITS'(s1_robin_ff ? robin_rd : plain_rd);
            s1_result.preemptible = s1_robin_ff;
         end else begin
            s1_result.status      = tlrq_pkg::STATUS_EMPTY;
            s1_result.served_id   = '0;
            s1_result.preemptible = 1'b0;
         end
      end else begin
         s1_result.status      = s1_ok_ff ? tlrq_pkg::STATUS_PUSHED
                                          : tlrq_pkg::STATUS_FULL;
         s1_result.served_id   = FIELD_BITS'(s1_id_ff);
         s1_result.preemptible = s1_robin_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= s1_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sim/tlrq_checker.sv
`timescale 1ns / 1ps
// scoreboard for the two-level ready queue dispatcher: predicts each result and checks it
module tlrq_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire tlrq_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire tlrq_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     full_count,
   output int                     empty_count
);

   localparam int DEPTH      = 16;
   localparam int PLAIN_Q    = 0;
   localparam int ROBIN_Q    = 1;
   localparam int SHOW_LIMIT = 10;

   // shadow copy of both ready queues and the policy register
   logic [tlrq_pkg::ID_FIELD_BITS-1:0] slot_ids   [2][DEPTH];
   logic [3:0]                         slot_head  [2];
   logic [4:0]                         slot_count [2];
   logic [1:0]                         sched_policy;

   // results still owed by the block, oldest first
   tlrq_pkg::rsp_type awaited_rsp [$];

   // apply one push or pop to the shadow queues and return its result
   function automatic tlrq_pkg::rsp_type dispatch(input tlrq_pkg::req_type r);
      tlrq_pkg::rsp_type res;
      int                q;
      logic [3:0]        tail;
      res = '0;
      if (r.mode == tlrq_pkg::MODE_PUSH) begin
         // fresh or unblocked processes go round robin under feedback
         q = (sched_policy == tlrq_pkg::POLICY_RR ||
              (sched_policy == tlrq_pkg::POLICY_FEEDBACK && r.arrived_new_or_blocked)) ?
             ROBIN_Q : PLAIN_Q;
         res.served_id   = r.process_id;
         res.preemptible = (q == ROBIN_Q);
         if (slot_count[q] == DEPTH) begin
            res.status = tlrq_pkg::STATUS_FULL;
         end else begin
            tail = slot_head[q] + slot_count[q][3:0];
            slot_ids[q][tail] = r.process_id;
            slot_count[q]     = slot_count[q] + 5'd1;
            res.status        = tlrq_pkg::STATUS_PUSHED;
         end
      end else begin
         // feedback drains the round robin queue first
         q = (sched_policy == tlrq_pkg::POLICY_RR ||
              (sched_policy == tlrq_pkg::POLICY_FEEDBACK && slot_count[ROBIN_Q] != 0)) ?
             ROBIN_Q : PLAIN_Q;
         if (slot_count[q] == 0) begin
            res.status = tlrq_pkg::STATUS_EMPTY;
         end else begin
            res.status      = tlrq_pkg::STATUS_POPPED;
            res.served_id   = slot_ids[q][slot_head[q]];
            res.preemptible = (q == ROBIN_Q);
            slot_head[q]    = slot_head[q] + 4'd1;
            slot_count[q]   = slot_count[q] - 5'd1;
         end
      end
      return res;
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin
      tlrq_pkg::rsp_type want;
      if (reset) begin
         for (int q = 0; q < 2; q++) begin
            slot_head[q]  = '0;
            slot_count[q] = '0;
         end
         sched_policy = tlrq_pkg::POLICY_FIFO;
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready)
            sched_policy = csr_data;
         if (req_valid && !req_stall)
            awaited_rsp.push_back(dispatch(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (rsp_data.status == tlrq_pkg::STATUS_FULL)
               full_count++;
            if (rsp_data.status == tlrq_pkg::STATUS_EMPTY)
               empty_count++;
            if (awaited_rsp.size() == 0) begin
               if (fail_count < SHOW_LIMIT)
                  $display("%0t: result with none outstanding: status %0d id %h pre %0d",
                           $time, rsp_data.status, rsp_data.served_id,
                           rsp_data.preemptible);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.served_id !== want.served_id ||
                   rsp_data.preemptible !== want.preemptible) begin
                  if (fail_count < SHOW_LIMIT) begin
                     $write("%0t: result %0d wrong: expected status %0d id %h pre %0d,",
                            $time, result_count, want.status, want.served_id,
                            want.preemptible);
                     $display(" got status %0d id %h pre %0d",
                              rsp_data.status, rsp_data.served_id,
                              rsp_data.preemptible);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the two-level ready queue dispatcher: stimulus, stalls and verdict
module tb_top;

   localparam logic [1:0] POLICY_UNUSED  = 2'd3;
   localparam int         IDLE_PCT       = 25;
   localparam int         HOLD_CYCLES    = 150;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         WATCHDOG_LIMIT = 5000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tlrq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tlrq_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_data;

   int fail_count;
   int pending_count;
   int result_count;
   int full_count;
   int empty_count;

   // stimulus controls shared with the receiver process
   bit calm;
   int holds_asked;
   int holds_granted;
   int hold_left;
   int idle_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   two_level_ready_queue_dispatch_top #(
      .QUEUE_DEPTH(16),
      .ID_BITS    (16)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   tlrq_checker checker_u (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .result_count (result_count),
      .full_count   (full_count),
      .empty_count  (empty_count)
   );

   // receiver: random stalls, quiet stretches and requested long hold-offs
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         holds_granted = holds_granted + 1;
         hold_left     = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, pending_count);
         $display("two_level_ready_queue_dispatch_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic tlrq_pkg::req_type req_of(input logic mode, input logic [15:0] id,
                                                input logic fresh);
      tlrq_pkg::req_type r;
      r.mode                   = mode;
      r.process_id             = id;
      r.arrived_new_or_blocked = fresh;
      return r;
   endfunction

   function automatic tlrq_pkg::req_type random_req(input int push_pct);
      return req_of(($urandom_range(0, 99) < push_pct) ? tlrq_pkg::MODE_PUSH
                                                        : tlrq_pkg::MODE_POP,
                    16'($urandom), 1'($urandom_range(0, 1)));
   endfunction

   // offer one transaction, return just after the edge that takes it
   task automatic push_req(input tlrq_pkg::req_type r);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // policy write, only while the block is idle
   task automatic write_policy(input logic [1:0] pol);
      csr_valid <= 1'b1;
      csr_data  <= pol;
      @(negedge clock);
      while (!csr_ready)
         @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [1:0] pol, input int items, input int push_pct,
                            input bit quiet, input bit hold);
      drain();
      write_policy(pol);
      calm = quiet;
      for (int i = 0; i < items; i++) begin
         if (hold && i == 20)
            holds_asked = holds_asked + 1;
         push_req(random_req(push_pct));
      end
      calm = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fifo after reset: empty pop, extreme ids, ignored pop fields
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'hFFFF, 1'b1));
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'hFFFF, 1'b1));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'hFFFF, 1'b1));
      drain();

      // feedback: fresh process jumps ahead of the plain one
      write_policy(tlrq_pkg::POLICY_FEEDBACK);
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'h1234, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'hABCD, 1'b1));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      drain();

      // round robin ignores the arrival flag
      write_policy(tlrq_pkg::POLICY_RR);
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'h5555, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      drain();

      // unused policy code behaves as fifo
      write_policy(POLICY_UNUSED);
      push_req(req_of(tlrq_pkg::MODE_PUSH, 16'hAAAA, 1'b1));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));
      push_req(req_of(tlrq_pkg::MODE_POP, 16'h0000, 1'b0));

      // random phases; push-heavy ones fill the queues to overflow
      run_phase(tlrq_pkg::POLICY_FEEDBACK, 100, 60, 1'b0, 1'b1);
      run_phase(tlrq_pkg::POLICY_RR,        90, 85, 1'b0, 1'b0);
      run_phase(tlrq_pkg::POLICY_RR,        60, 20, 1'b0, 1'b0);
      run_phase(tlrq_pkg::POLICY_FIFO,      90, 80, 1'b0, 1'b0);
      run_phase(POLICY_UNUSED,              90, 30, 1'b0, 1'b0);
      run_phase(tlrq_pkg::POLICY_FEEDBACK, 100, 55, 1'b1, 1'b0);
      run_phase(tlrq_pkg::POLICY_FEEDBACK,  80, 70, 1'b0, 1'b1);
      run_phase(tlrq_pkg::POLICY_FIFO,     100, 50, 1'b0, 1'b0);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d results, %0d full-queue drops and %0d empty pops",
               result_count, full_count, empty_count);
      $display("all four policy codes, receiver hold-offs and idle-free stretches run");
      if (fail_count == 0)
         $display("two_level_ready_queue_dispatch_top: match");
      else
         $display("two_level_ready_queue_dispatch_top: mismatch");
      $finish;
   end

endmodule

// File: files.f
design/tlrq_pkg.sv
design/tlrq_queue.sv
design/two_level_ready_queue_dispatch_top.sv
sim/tlrq_checker.sv
sim/tb_top.sv
